### hw/rtl/assert_macros.svh
// assertion macros shared by the switch rtl
// expects a clock named clk and a reset named rst in the using module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define BSW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// condition in one cycle implies another in the next
`define BSW_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

### hw/rtl/bsw_pkg.sv
// types and constants for the buffered switch
// used by the controller, datapath and top level
`default_nettype none

package bsw_pkg;

  localparam int PORT_W  = 3;
  localparam int DEST_W  = 4;
  localparam int ID_W    = 31;
  localparam int WORD_W  = DEST_W + ID_W;
  localparam int ROUTE_W = 48;
  localparam int CAP_W   = 5;
  localparam int CMD_W   = 4;

  localparam logic [CAP_W-1:0] CAP_RESET    = 5'd4;
  localparam logic [CAP_W-1:0] CREDIT_RESET = 5'd4;

  localparam logic [1:0] OP_ARRIVAL = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_SEND    = 2'd2;
  localparam logic [1:0] OP_CREDIT  = 2'd3;

  localparam logic [1:0] KIND_SENT   = 2'd0;
  localparam logic [1:0] KIND_CREDIT = 2'd1;
  localparam logic [1:0] KIND_DROP   = 2'd2;
  localparam logic [1:0] KIND_DONE   = 2'd3;

  localparam logic [1:0] CFG_ROUTE      = 2'd0;
  localparam logic [1:0] CFG_EXIT_CAP   = 2'd1;
  localparam logic [1:0] CFG_ENTRY_CAP  = 2'd2;

  localparam logic [CMD_W-1:0] CMD_NONE      = 4'd0;
  localparam logic [CMD_W-1:0] CMD_LATCH     = 4'd1;
  localparam logic [CMD_W-1:0] CMD_PUSH      = 4'd2;
  localparam logic [CMD_W-1:0] CMD_EMIT_DROP = 4'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 4'd4;
  localparam logic [CMD_W-1:0] CMD_SCAN_RD   = 4'd5;
  localparam logic [CMD_W-1:0] CMD_SCAN_CMP  = 4'd6;
  localparam logic [CMD_W-1:0] CMD_MOVE      = 4'd7;
  localparam logic [CMD_W-1:0] CMD_SEND_RD   = 4'd8;
  localparam logic [CMD_W-1:0] CMD_SEND      = 4'd9;
  localparam logic [CMD_W-1:0] CMD_CREDIT    = 4'd10;
  localparam logic [CMD_W-1:0] CMD_EMIT_DONE = 4'd11;

  typedef struct packed {
    logic [1:0]        operation;
    logic [PORT_W-1:0] port;
    logic [DEST_W-1:0] dest;
    logic [ID_W-1:0]   msg_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [PORT_W-1:0] port_out;
    logic [DEST_W-1:0] dest_out;
    logic [ID_W-1:0]   id_out;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [CMD_W-1:0]  code;
    logic [PORT_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       drop;
    logic       move_ok;
    logic       send_ok;
    logic       out_free;
  } sts_t;

endpackage

`default_nettype wire

### hw/rtl/bsw_ram.sv
// generic simple dual-port ram with registered read
// no dependencies
`default_nettype none

module bsw_ram #(
  parameter int WIDTH = 35,
  parameter int DEPTH = 112
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/bsw_datapath.sv
// switch datapath: config registers, fifo pointers, credits, arbitration
// registers, entry and exit memories, output register; uses bsw_pkg, bsw_ram
`default_nettype none
`include "assert_macros.svh"

module bsw_datapath #(
  parameter int PORTS      = 7,
  parameter int FIFO_DEPTH = 16,
  parameter int DEST_COUNT = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire bsw_pkg::in_item_t             in_data,
  input  wire logic                          out_stall,
  output      logic                          out_valid,
  output      bsw_pkg::out_item_t            out_data,
  input  wire logic                          cfg_valid,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [bsw_pkg::ROUTE_W-1:0]   cfg_data,
  input  wire bsw_pkg::cmd_t                 cmd,
  output      bsw_pkg::sts_t                 sts
);

  localparam int PW    = $clog2(PORTS);
  localparam int SW    = $clog2(FIFO_DEPTH);
  localparam int FW    = $clog2(FIFO_DEPTH + 1);
  localparam int TOTAL = PORTS * FIFO_DEPTH;
  localparam int AW    = $clog2(TOTAL);
  localparam int WW    = bsw_pkg::WORD_W;
  localparam int IW    = bsw_pkg::ID_W;
  localparam int CPW   = bsw_pkg::CAP_W;

  bsw_pkg::in_item_t             item;
  logic [bsw_pkg::ROUTE_W-1:0]   route_map;
  logic [CPW-1:0]                exit_cap;
  logic [CPW-1:0]                entry_cap;
  logic [FW-1:0]                 entry_fill [PORTS];
  logic [SW-1:0]                 entry_head [PORTS];
  logic [FW-1:0]                 exit_fill  [PORTS];
  logic [SW-1:0]                 exit_head  [PORTS];
  logic [CPW-1:0]                credit     [PORTS-1];
  logic                          best_valid [PORTS];
  logic [PW-1:0]                 best_src   [PORTS];
  logic [WW-1:0]                 best_word  [PORTS];

  logic [WW-1:0] entry_rdata;
  logic [WW-1:0] exit_rdata;
  logic          entry_we;
  logic [AW-1:0] entry_waddr;
  logic          entry_re;
  logic [AW-1:0] entry_raddr;
  logic          exit_we;
  logic [AW-1:0] exit_waddr;
  logic          exit_re;
  logic [AW-1:0] exit_raddr;

  logic [PW-1:0] idx;
  logic [PW-1:0] ip;
  logic [PW-1:0] src;
  logic          port_ok;
  logic          drop;
  logic          move_ok;
  logic          send_ok;
  logic          out_free;
  logic [2:0]    route;
  logic          route_ok;
  logic [PW-1:0] rp;
  logic          scan_upd;
  logic          emit;
  bsw_pkg::out_item_t emit_data;

  function automatic logic is_full(input logic [FW-1:0] f, input logic [CPW-1:0] cap);
    return (8'(f) >= 8'(cap)) || (8'(f) >= 8'(FIFO_DEPTH));
  endfunction

  function automatic logic [SW-1:0] tail_slot(input logic [SW-1:0] h, input logic [FW-1:0] f);
    logic [SW+1:0] s;
    s = (SW+2)'(h) + (SW+2)'(f);
    if (s >= (SW+2)'(FIFO_DEPTH)) begin
      s = s - (SW+2)'(FIFO_DEPTH);
    end
    return s[SW-1:0];
  endfunction

  function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] h);
    return (h == SW'(FIFO_DEPTH - 1)) ? '0 : h + 1'b1;
  endfunction

  function automatic logic [AW-1:0] mem_addr(input logic [PW-1:0] p, input logic [SW-1:0] s);
    return AW'(AW'(p) * AW'(FIFO_DEPTH) + AW'(s));
  endfunction

  assign idx      = cmd.idx[PW-1:0];
  assign ip       = item.port[PW-1:0];
  assign src      = best_src[idx];
  assign port_ok  = {1'b0, item.port} < 4'(PORTS);
  assign drop     = !port_ok || ({1'b0, item.dest} >= 5'(DEST_COUNT)) ||
                    is_full(entry_fill[ip], entry_cap);
  assign move_ok  = best_valid[idx] && !is_full(exit_fill[idx], exit_cap);
  assign send_ok  = (exit_fill[idx] != '0) &&
                    ((cmd.idx >= 3'(PORTS - 1)) || (credit[idx] != '0));
  assign out_free = !out_valid || !out_stall;

  assign route    = route_map[6'(entry_rdata[WW-1:IW]) * 6'd3 +: 3];
  assign route_ok = {1'b0, route} < 4'(PORTS);
  assign rp       = route[PW-1:0];
  assign scan_upd = (cmd.code == bsw_pkg::CMD_SCAN_CMP) && (entry_fill[idx] != '0) &&
                    route_ok &&
                    (!best_valid[rp] || (entry_rdata[IW-1:0] < best_word[rp][IW-1:0]));

  assign sts.op       = item.operation;
  assign sts.drop     = drop;
  assign sts.move_ok  = move_ok;
  assign sts.send_ok  = send_ok;
  assign sts.out_free = out_free;

  // memory ports
  assign entry_we    = cmd.code == bsw_pkg::CMD_PUSH;
  assign entry_waddr = mem_addr(ip, tail_slot(entry_head[ip], entry_fill[ip]));
  assign entry_re    = cmd.code == bsw_pkg::CMD_SCAN_RD;
  assign entry_raddr = mem_addr(idx, entry_head[idx]);
  assign exit_we     = cmd.code == bsw_pkg::CMD_MOVE;
  assign exit_waddr  = mem_addr(idx, tail_slot(exit_head[idx], exit_fill[idx]));
  assign exit_re     = cmd.code == bsw_pkg::CMD_SEND_RD;
  assign exit_raddr  = mem_addr(idx, exit_head[idx]);

  bsw_ram #(.WIDTH(WW), .DEPTH(TOTAL)) u_entry_ram (
    .clk   (clk),
    .we    (entry_we),
    .waddr (entry_waddr),
    .wdata ({item.dest, item.msg_id}),
    .re    (entry_re),
    .raddr (entry_raddr),
    .rdata (entry_rdata)
  );

  bsw_ram #(.WIDTH(WW), .DEPTH(TOTAL)) u_exit_ram (
    .clk   (clk),
    .we    (exit_we),
    .waddr (exit_waddr),
    .wdata (best_word[idx]),
    .re    (exit_re),
    .raddr (exit_raddr),
    .rdata (exit_rdata)
  );

  // result selection
  always_comb begin
    emit      = 1'b0;
    emit_data = '0;
    case (cmd.code)
      bsw_pkg::CMD_EMIT_DROP: begin
        emit               = 1'b1;
        emit_data.kind     = bsw_pkg::KIND_DROP;
        emit_data.port_out = item.port;
        emit_data.dest_out = item.dest;
        emit_data.id_out   = item.msg_id;
      end
      bsw_pkg::CMD_MOVE: begin
        emit               = 1'b1;
        emit_data.kind     = bsw_pkg::KIND_CREDIT;
        emit_data.port_out = 3'(src);
      end
      bsw_pkg::CMD_SEND: begin
        emit               = 1'b1;
        emit_data.kind     = bsw_pkg::KIND_SENT;
        emit_data.port_out = cmd.idx;
        emit_data.dest_out = exit_rdata[WW-1:IW];
        emit_data.id_out   = exit_rdata[IW-1:0];
      end
      bsw_pkg::CMD_EMIT_DONE: begin
        emit               = 1'b1;
        emit_data.kind     = bsw_pkg::KIND_DONE;
        emit_data.last     = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      route_map <= '0;
      exit_cap  <= bsw_pkg::CAP_RESET;
      entry_cap <= bsw_pkg::CAP_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        bsw_pkg::CFG_ROUTE:     route_map <= cfg_data;
        bsw_pkg::CFG_EXIT_CAP:  exit_cap  <= cfg_data[CPW-1:0];
        bsw_pkg::CFG_ENTRY_CAP: entry_cap <= cfg_data[CPW-1:0];
        default: begin
        end
      endcase
    end
  end

  // fifo pointers, credits and arbitration flags
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < PORTS; p++) begin
        entry_fill[p] <= '0;
        entry_head[p] <= '0;
        exit_fill[p]  <= '0;
        exit_head[p]  <= '0;
        best_valid[p] <= 1'b0;
      end
      for (int p = 0; p < PORTS - 1; p++) begin
        credit[p] <= bsw_pkg::CREDIT_RESET;
      end
    end else begin
      case (cmd.code)
        bsw_pkg::CMD_PUSH: begin
          entry_fill[ip] <= entry_fill[ip] + 1'b1;
        end
        bsw_pkg::CMD_CLEAR: begin
          for (int p = 0; p < PORTS; p++) begin
            best_valid[p] <= 1'b0;
          end
        end
        bsw_pkg::CMD_SCAN_CMP: begin
          if (scan_upd) begin
            best_valid[rp] <= 1'b1;
          end
        end
        bsw_pkg::CMD_MOVE: begin
          entry_fill[src] <= entry_fill[src] - 1'b1;
          entry_head[src] <= next_slot(entry_head[src]);
          exit_fill[idx]  <= exit_fill[idx] + 1'b1;
        end
        bsw_pkg::CMD_SEND: begin
          exit_fill[idx] <= exit_fill[idx] - 1'b1;
          exit_head[idx] <= next_slot(exit_head[idx]);
          if (cmd.idx < 3'(PORTS - 1)) begin
            credit[idx] <= credit[idx] - 1'b1;
          end
        end
        bsw_pkg::CMD_CREDIT: begin
          if ((item.port < 3'(PORTS - 1)) && (credit[ip] < entry_cap) &&
              (8'(credit[ip]) < 8'(FIFO_DEPTH))) begin
            credit[ip] <= credit[ip] + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.code == bsw_pkg::CMD_LATCH) begin
      item <= in_data;
    end
    if (scan_upd) begin
      best_src[rp]  <= idx;
      best_word[rp] <= entry_rdata;
    end
    if (emit) begin
      out_data <= emit_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  `BSW_ASSERT(a_emit_free, (emit) |-> (out_free), "result loaded over a pending transfer")
  `BSW_ASSERT(a_move_ok, (cmd.code == bsw_pkg::CMD_MOVE) |-> (move_ok), "move without a choice")
  `BSW_ASSERT(a_fill_max, (entry_fill[0] <= FW'(FIFO_DEPTH)), "entry fifo overfilled")

endmodule

`default_nettype wire

### hw/rtl/bsw_ctrl.sv
// switch controller: sequences arrivals, period ticks, send ticks
// and credit returns; uses bsw_pkg
`default_nettype none
`include "assert_macros.svh"

module bsw_ctrl #(
  parameter int PORTS = 7
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output      logic          in_stall,
  output      bsw_pkg::cmd_t cmd,
  input  wire bsw_pkg::sts_t sts
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DISPATCH  = 4'd1;
  localparam logic [3:0] S_ARRIVE    = 4'd2;
  localparam logic [3:0] S_SCAN_RD   = 4'd3;
  localparam logic [3:0] S_SCAN_CMP  = 4'd4;
  localparam logic [3:0] S_MOVE      = 4'd5;
  localparam logic [3:0] S_SEND_CHK  = 4'd6;
  localparam logic [3:0] S_SEND_EMIT = 4'd7;
  localparam logic [3:0] S_DONE      = 4'd8;

  localparam logic [bsw_pkg::PORT_W-1:0] LAST_IDX = bsw_pkg::PORT_W'(PORTS - 1);

  logic [3:0]                 state;
  logic [3:0]                 state_next;
  logic [bsw_pkg::PORT_W-1:0] idx;
  logic [bsw_pkg::PORT_W-1:0] idx_next;
  logic                       at_last;

  assign in_stall = state != S_IDLE;
  assign at_last  = idx == LAST_IDX;

  always_comb begin
    state_next = state;
    idx_next   = idx;
    cmd.code   = bsw_pkg::CMD_NONE;
    cmd.idx    = idx;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.code   = bsw_pkg::CMD_LATCH;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        idx_next = '0;
        case (sts.op)
          bsw_pkg::OP_ARRIVAL: state_next = S_ARRIVE;
          bsw_pkg::OP_TICK: begin
            cmd.code   = bsw_pkg::CMD_CLEAR;
            state_next = S_SCAN_RD;
          end
          bsw_pkg::OP_SEND: state_next = S_SEND_CHK;
          default: begin
            cmd.code   = bsw_pkg::CMD_CREDIT;
            state_next = S_DONE;
          end
        endcase
      end
      S_ARRIVE: begin
        if (!sts.drop) begin
          cmd.code   = bsw_pkg::CMD_PUSH;
          state_next = S_DONE;
        end else if (sts.out_free) begin
          cmd.code   = bsw_pkg::CMD_EMIT_DROP;
          state_next = S_DONE;
        end
      end
      S_SCAN_RD: begin
        cmd.code   = bsw_pkg::CMD_SCAN_RD;
        state_next = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        cmd.code = bsw_pkg::CMD_SCAN_CMP;
        if (at_last) begin
          idx_next   = '0;
          state_next = S_MOVE;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = S_SCAN_RD;
        end
      end
      S_MOVE: begin
        if (!sts.move_ok || sts.out_free) begin
          if (sts.move_ok) begin
            cmd.code = bsw_pkg::CMD_MOVE;
          end
          if (at_last) begin
            state_next = S_DONE;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
      S_SEND_CHK: begin
        if (sts.send_ok) begin
          cmd.code   = bsw_pkg::CMD_SEND_RD;
          state_next = S_SEND_EMIT;
        end else if (at_last) begin
          state_next = S_DONE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      S_SEND_EMIT: begin
        if (sts.out_free) begin
          cmd.code = bsw_pkg::CMD_SEND;
          if (at_last) begin
            state_next = S_DONE;
          end else begin
            idx_next   = idx + 1'b1;
            state_next = S_SEND_CHK;
          end
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.code   = bsw_pkg::CMD_EMIT_DONE;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  `BSW_ASSERT(a_send_seq, (state == S_SEND_EMIT) |-> ($past(state) == S_SEND_CHK || $past(state) == S_SEND_EMIT), "send emit without a head read")

endmodule

`default_nettype wire

### hw/rtl/buffered_switch_oldest_first_credit_unit.sv
// Seven-port buffered switch with a fifo per entry and exit port, oldest-first
// arbitration and credit flow control. Items are taken one at a time and the next
// item can be accepted in the cycle after the done result of the last one is loaded.
// An arrival goes through dispatch and an arrive step, a credit return through
// dispatch, a send tick through dispatch, a check per port and a head read and
// emit per port that sends, and a period tick through dispatch, a read and
// compare per port on the entry heads through the single read port of the entry
// memory, and a move per port. Each result leaves through one output register,
// one transfer per cycle while not stalled; a stalled output holds the sequence
// at each step that loads a result. Uses bsw_pkg, bsw_ctrl, bsw_datapath.
`default_nettype none

module buffered_switch_oldest_first_credit_unit #(
  parameter int PORTS      = 7,
  parameter int FIFO_DEPTH = 16,
  parameter int DEST_COUNT = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output      logic                        in_stall,
  input  wire bsw_pkg::in_item_t           in_data,
  output      logic                        out_valid,
  input  wire logic                        out_stall,
  output      bsw_pkg::out_item_t          out_data,
  input  wire logic                        cfg_valid,
  output      logic                        cfg_ready,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [bsw_pkg::ROUTE_W-1:0] cfg_data
);

  bsw_pkg::cmd_t cmd;
  bsw_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  bsw_ctrl #(.PORTS(PORTS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  bsw_datapath #(
    .PORTS      (PORTS),
    .FIFO_DEPTH (FIFO_DEPTH),
    .DEST_COUNT (DEST_COUNT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire

### bench/tb_buffered_switch_oldest_first_credit_unit.sv
// testbench for the seven-port buffered switch with oldest-first arbitration
// drives items through a directed table and random traffic, checks against a local predictor
// depends on bsw_pkg and buffered_switch_oldest_first_credit_unit
`timescale 1ns / 1ps
`default_nettype none

module tb_buffered_switch_oldest_first_credit_unit;

  localparam int NPORT = 7;
  localparam int DEPTH = 16;
  localparam int NCRED = NPORT - 1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  bsw_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  bsw_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [bsw_pkg::ROUTE_W-1:0] cfg_data = '0;

  always #10 clk = ~clk;

  buffered_switch_oldest_first_credit_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // switch state mirror
  logic [bsw_pkg::ROUTE_W-1:0] sw_route;
  logic [bsw_pkg::CAP_W-1:0] sw_exit_cap, sw_entry_cap;
  logic [bsw_pkg::WORD_W-1:0] ent_mem [NPORT][DEPTH];
  logic [bsw_pkg::WORD_W-1:0] ext_mem [NPORT][DEPTH];
  int ent_fill [NPORT], ent_head [NPORT], ext_fill [NPORT], ext_head [NPORT];
  int credits [NPORT];

  bsw_pkg::out_item_t pending_results [$];
  int errors = 0;
  int in_idle_pct = 30, out_idle_pct = 30;

  typedef struct {
    bsw_pkg::in_item_t item;
    bit fixed;
    bsw_pkg::out_item_t want;
  } row_t;

  function automatic int cap_of(logic [bsw_pkg::CAP_W-1:0] c);
    return (c > DEPTH) ? DEPTH : int'(c);
  endfunction

  function automatic int exit_for(logic [bsw_pkg::WORD_W-1:0] w);
    return int'((sw_route >> (3 * int'(w[bsw_pkg::WORD_W-1:bsw_pkg::ID_W]))) & 48'h7);
  endfunction

  function automatic bsw_pkg::out_item_t mk(logic [1:0] k, int p,
                                            logic [bsw_pkg::WORD_W-1:0] w, bit l);
    bsw_pkg::out_item_t r;
    r.kind = k;
    r.port_out = bsw_pkg::PORT_W'(p);
    r.dest_out = w[bsw_pkg::WORD_W-1:bsw_pkg::ID_W];
    r.id_out = w[bsw_pkg::ID_W-1:0];
    r.last = l;
    return r;
  endfunction

  task automatic switch_reset();
    sw_route = '0;
    sw_exit_cap = bsw_pkg::CAP_RESET;
    sw_entry_cap = bsw_pkg::CAP_RESET;
    for (int i = 0; i < NPORT; i++) begin
      ent_fill[i] = 0; ent_head[i] = 0; ext_fill[i] = 0; ext_head[i] = 0;
      credits[i] = 4;
    end
  endtask

  // compute results of one item and update the mirror
  task automatic predict_switch(bsw_pkg::in_item_t it);
    int pick [NPORT];
    int p, slot, src;
    logic [bsw_pkg::WORD_W-1:0] w, h, best;
    bit found;
    p = int'(it.port);
    w = {it.dest, it.msg_id};
    case (it.operation)
      bsw_pkg::OP_ARRIVAL: begin
        if (p >= NPORT || ent_fill[p] >= cap_of(sw_entry_cap)) begin
          pending_results.push_back(mk(bsw_pkg::KIND_DROP, p, w, 1'b0));
        end else begin
          slot = (ent_head[p] + ent_fill[p]) % DEPTH;
          ent_mem[p][slot] = w;
          ent_fill[p]++;
        end
      end
      bsw_pkg::OP_TICK: begin
        for (int i = 0; i < NPORT; i++) begin
          pick[i] = -1;
          found = 0;
          best = '0;
          if (ext_fill[i] >= cap_of(sw_exit_cap)) continue;
          for (int e = 0; e < NPORT; e++) begin
            if (ent_fill[e] == 0) continue;
            h = ent_mem[e][ent_head[e]];
            if (exit_for(h) != i) continue;
            if (!found || h[bsw_pkg::ID_W-1:0] < best[bsw_pkg::ID_W-1:0]) begin
              found = 1; best = h; pick[i] = e;
            end
          end
        end
        for (int i = 0; i < NPORT; i++) begin
          if (pick[i] < 0) continue;
          src = pick[i];
          if (ent_fill[src] == 0) continue;
          h = ent_mem[src][ent_head[src]];
          ent_head[src] = (ent_head[src] + 1) % DEPTH;
          ent_fill[src]--;
          slot = (ext_head[i] + ext_fill[i]) % DEPTH;
          ext_mem[i][slot] = h;
          ext_fill[i]++;
          pending_results.push_back(mk(bsw_pkg::KIND_CREDIT, src, '0, 1'b0));
        end
      end
      bsw_pkg::OP_SEND: begin
        for (int i = 0; i < NPORT; i++) begin
          if (i < NCRED && credits[i] == 0) continue;
          if (ext_fill[i] == 0) continue;
          h = ext_mem[i][ext_head[i]];
          ext_head[i] = (ext_head[i] + 1) % DEPTH;
          ext_fill[i]--;
          pending_results.push_back(mk(bsw_pkg::KIND_SENT, i, h, 1'b0));
          if (i < NCRED) credits[i]--;
        end
      end
      default: begin
        if (p < NCRED && credits[p] < cap_of(sw_entry_cap)) credits[p]++;
      end
    endcase
    pending_results.push_back(mk(bsw_pkg::KIND_DONE, 0, '0, 1'b1));
  endtask

  task automatic report_mismatch(string what, bsw_pkg::out_item_t got,
                                 bsw_pkg::out_item_t want);
    errors++;
    $display("mismatch %s: got kind %0d port %0d dest %0d id %0h last %0d, %s %0d %0d %0d %0h %0d",
      what, got.kind, got.port_out, got.dest_out, got.id_out, got.last, "want",
      want.kind, want.port_out, want.dest_out, want.id_out, want.last);
  endtask

  // result checking and receiver stalls
  always @(posedge clk) begin
    bsw_pkg::out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected", out_data, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.kind !== want.kind) report_mismatch("kind", out_data, want);
        else if (out_data.port_out !== want.port_out) report_mismatch("port", out_data, want);
        else if (out_data.dest_out !== want.dest_out) report_mismatch("dest", out_data, want);
        else if (out_data.id_out !== want.id_out) report_mismatch("id", out_data, want);
        else if (out_data.last !== want.last) report_mismatch("last", out_data, want);
      end
    end
    out_stall <= ($urandom_range(99) < out_idle_pct);
  end

  task automatic send_item(bsw_pkg::in_item_t it);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_switch(it);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [bsw_pkg::ROUTE_W-1:0] v);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      bsw_pkg::CFG_ROUTE: sw_route = v;
      bsw_pkg::CFG_EXIT_CAP: sw_exit_cap = v[bsw_pkg::CAP_W-1:0];
      default: sw_entry_cap = v[bsw_pkg::CAP_W-1:0];
    endcase
  endtask

  function automatic bsw_pkg::in_item_t mk_in(logic [1:0] op, int p, int d,
                                              logic [bsw_pkg::ID_W-1:0] id);
    bsw_pkg::in_item_t r;
    r.operation = op;
    r.port = bsw_pkg::PORT_W'(p);
    r.dest = bsw_pkg::DEST_W'(d);
    r.msg_id = id;
    return r;
  endfunction

  function automatic logic [bsw_pkg::ROUTE_W-1:0] rand_route(bit wild);
    logic [bsw_pkg::ROUTE_W-1:0] r;
    r = '0;
    for (int d = 0; d < 16; d++)
      r[3*d +: 3] = wild ? 3'($urandom_range(7)) : 3'($urandom_range(6));
    return r;
  endfunction

  task automatic run_random(int count);
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 45)
        send_item(mk_in(bsw_pkg::OP_ARRIVAL, (r < 2) ? 7 : $urandom_range(6),
                        $urandom_range(15),
                        (r < 10) ? bsw_pkg::ID_W'($urandom_range(15))
                                 : bsw_pkg::ID_W'($urandom)));
      else if (r < 65) send_item(mk_in(bsw_pkg::OP_TICK, $urandom_range(7), 0, '0));
      else if (r < 85) send_item(mk_in(bsw_pkg::OP_SEND, $urandom_range(7), 0, '0));
      else send_item(mk_in(bsw_pkg::OP_CREDIT, $urandom_range(7), $urandom_range(15),
                           bsw_pkg::ID_W'($urandom)));
    end
  endtask

  initial begin
    row_t rows [$];
    row_t rw;
    switch_reset();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    rw.fixed = 1;
    rw.item = mk_in(bsw_pkg::OP_TICK, 0, 0, '0);
    rw.want = mk(bsw_pkg::KIND_DONE, 0, '0, 1); rows.push_back(rw);
    rw.item = mk_in(bsw_pkg::OP_SEND, 0, 0, '0); rows.push_back(rw);
    rw.item = mk_in(bsw_pkg::OP_ARRIVAL, 7, 15, '1);
    rw.want = mk(bsw_pkg::KIND_DROP, 7, {4'hf, 31'h7fffffff}, 0); rows.push_back(rw);
    rw.fixed = 0;
    for (int i = 0; i < 4; i++) begin
      rw.item = mk_in(bsw_pkg::OP_ARRIVAL, 0, i, bsw_pkg::ID_W'(10 - i)); rows.push_back(rw);
    end
    rw.item = mk_in(bsw_pkg::OP_ARRIVAL, 0, 5, '0); rows.push_back(rw);  // full entry fifo
    rw.item = mk_in(bsw_pkg::OP_ARRIVAL, 3, 0, '0); rows.push_back(rw);
    rw.item = mk_in(bsw_pkg::OP_ARRIVAL, 6, 15, '1); rows.push_back(rw);
    rw.item = mk_in(bsw_pkg::OP_ARRIVAL, 2, 7, bsw_pkg::ID_W'(3)); rows.push_back(rw);
    rw.item = mk_in(bsw_pkg::OP_TICK, 0, 0, '0); rows.push_back(rw);
    rw.item = mk_in(bsw_pkg::OP_TICK, 0, 0, '0); rows.push_back(rw);
    for (int i = 0; i < 6; i++) begin
      rw.item = mk_in(bsw_pkg::OP_SEND, 0, 0, '0); rows.push_back(rw);
    end
    rw.item = mk_in(bsw_pkg::OP_CREDIT, 0, 0, '0); rows.push_back(rw);
    rw.item = mk_in(bsw_pkg::OP_CREDIT, 6, 0, '0); rows.push_back(rw);
    rw.item = mk_in(bsw_pkg::OP_CREDIT, 7, 0, '0); rows.push_back(rw);
    rw.item = mk_in(bsw_pkg::OP_TICK, 0, 0, '0); rows.push_back(rw);
    rw.item = mk_in(bsw_pkg::OP_SEND, 0, 0, '0); rows.push_back(rw);

    foreach (rows[k]) begin
      if (rows[k].fixed) begin
        send_item(rows[k].item);
        if (rows[k].want.kind == bsw_pkg::KIND_DROP &&
            pending_results[pending_results.size()-2] != rows[k].want)
          report_mismatch("table", pending_results[pending_results.size()-2], rows[k].want);
        if (pending_results[$] != mk(bsw_pkg::KIND_DONE, 0, '0, 1))
          report_mismatch("table", pending_results[$], mk(bsw_pkg::KIND_DONE, 0, '0, 1));
      end else begin
        send_item(rows[k].item);
      end
      if (k == 2) write_reg(bsw_pkg::CFG_ROUTE, 48'h0);
    end

    // spread routes, full capacities
    write_reg(bsw_pkg::CFG_ROUTE, rand_route(0));
    write_reg(bsw_pkg::CFG_EXIT_CAP, 48'd16);
    write_reg(bsw_pkg::CFG_ENTRY_CAP, 48'd16);
    in_idle_pct = 0; out_idle_pct = 0;
    run_random(30);
    in_idle_pct = 30; out_idle_pct = 30;

    // narrow capacities, some routes to no port
    write_reg(bsw_pkg::CFG_ROUTE, rand_route(1));
    write_reg(bsw_pkg::CFG_EXIT_CAP, 48'd1);
    write_reg(bsw_pkg::CFG_ENTRY_CAP, 48'd1);
    run_random(15);

    // zero and oversize capacities
    write_reg(bsw_pkg::CFG_EXIT_CAP, 48'd0);
    write_reg(bsw_pkg::CFG_ENTRY_CAP, 48'd31);
    run_random(15);
    write_reg(bsw_pkg::CFG_ROUTE, 48'hffff_ffff_ffff);
    write_reg(bsw_pkg::CFG_EXIT_CAP, 48'd31);
    write_reg(bsw_pkg::CFG_ENTRY_CAP, 48'd0);
    run_random(10);
    write_reg(bsw_pkg::CFG_ROUTE, rand_route(0));
    write_reg(bsw_pkg::CFG_ENTRY_CAP, 48'd5);
    run_random(16);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("tb_buffered_switch_oldest_first_credit_unit passed");
    else $display("tb_buffered_switch_oldest_first_credit_unit failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_buffered_switch_oldest_first_credit_unit failed");
    $finish;
  end

endmodule

`default_nettype wire

### files.f
+incdir+hw/rtl
hw/rtl/bsw_pkg.sv
hw/rtl/bsw_ram.sv
hw/rtl/bsw_datapath.sv
hw/rtl/bsw_ctrl.sv
hw/rtl/buffered_switch_oldest_first_credit_unit.sv
bench/tb_buffered_switch_oldest_first_credit_unit.sv
